// ===== src/sha512_224_pkg.sv =====
// Package: SHA-512/224 constants, types and round functions.
package sha512_224_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned Rounds  = 80;
  localparam int unsigned QDepth  = 4;

  typedef enum logic [0:0] {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_COMPRESS,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
  } result_t;

  localparam logic [63:0] TruncMask = 64'hffffffff00000000;
  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [6:0]  LenPos    = 7'd112;

  function automatic logic [63:0] iv(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0: r = 64'h8c3d37c819544da2;
      3'd1: r = 64'h73e1996689dcd4d6;
      3'd2: r = 64'h1dfab7ae32ff9c82;
      3'd3: r = 64'h679dd514582f9fcf;
      3'd4: r = 64'h0f6d2b697bd44da8;
      3'd5: r = 64'h77e36f7304c48942;
      3'd6: r = 64'h3f9d85a86a1d36c8;
      default: r = 64'h1112e6ad91d692a1;
    endcase
    return r;
  endfunction

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
    64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
    64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
    64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
    64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
    64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
    64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
    64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
    64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
    64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
    64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
    64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
    64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
    64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
    64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
    64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
    64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
    64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
    64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
    64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
    64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

// ===== src/sha512_224_if.sv =====
// Valid/ready channel interfaces for the hash engine.
interface sha512_224_in_if;
  logic                        valid;
  logic                        ready;
  sha512_224_pkg::op_e         op;
  logic [7:0]                  data_byte;
  modport source (output valid, op, data_byte, input ready);
  modport sink   (input valid, op, data_byte, output ready);
endinterface

interface sha512_224_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [1:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink   (input valid, digest_word, word_index, last, output ready);
endinterface

// ===== src/sha512_224_front.sv =====
// Front end: accepts items and queues them for the core.
module sha512_224_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sha512_224_in_if.sink         in_if,
  output sha512_224_pkg::item_t item_o,
  output logic                  item_valid_o,
  input  logic                  item_ready_i
);
  import sha512_224_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  item_t            mem_q [QDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [PtrW:0]    cnt_q;
  logic             push, pop;

  assign in_if.ready  = (cnt_q != (PtrW+1)'(QDepth));
  assign push         = in_if.valid && in_if.ready;
  assign item_valid_o = (cnt_q != '0);
  assign pop          = item_valid_o && item_ready_i;
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{op: in_if.op, data_byte: in_if.data_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

// ===== src/sha512_224_core.sv =====
// Back end: block buffer, padding, 80-round compression and digest output.
module sha512_224_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sha512_224_pkg::item_t item_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  sha512_224_out_if.source      out_if
);
  import sha512_224_pkg::*;

  state_e       state_q, state_d;
  logic [63:0]  h_q [8];
  logic [63:0]  v_q [8];
  logic [63:0]  w_q [16];
  logic [63:0]  blk_q [16];
  logic [6:0]   fill_q;
  logic [127:0] len_q;
  logic [6:0]   rnd_q;
  logic         fin_q;   // compression belongs to a finish
  logic [1:0]   widx_q;
  logic         ovalid_q;
  logic [63:0]  oword_q;
  logic [1:0]   oidx_q;

  logic [63:0]  wt, s0, s1, t1, t2, ch, mj;
  logic         put, start;
  logic [7:0]   put_byte;
  logic         take;
  logic         len_load;
  logic [63:0]  wload [16];

  // schedule: w_q[0] is the current word; window shifts each round
  always_comb begin
    s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
    s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
    wt = w_q[0];
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1 = v_q[7] + (rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41))
         + ch + RoundK[rnd_q] + wt;
    t2 = (rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39)) + mj;
  end

  assign take         = !ovalid_q || out_if.ready;
  assign item_ready_o = (state_q == ST_COLLECT);
  assign len_load     = (state_q == ST_PAD) && (fill_q == LenPos);

  // block as seen by the schedule at start, including this cycle's writes
  always_comb begin
    for (int i = 0; i < 16; i++) wload[i] = blk_q[i];
    if (len_load) begin
      wload[14] = len_q[127:64];
      wload[15] = len_q[63:0];
    end
    if (put) begin
      wload[15][7:0] = put_byte;
    end
  end

  always_comb begin
    state_d  = state_q;
    put      = 1'b0;
    put_byte = item_i.data_byte;
    start    = 1'b0;
    unique case (state_q)
      ST_COLLECT: begin
        if (item_valid_i) begin
          put = 1'b1;
          if (item_i.op == OP_FINISH) begin
            put_byte = PadByte;
          end
          if (fill_q == 7'd127) begin
            start   = 1'b1;
            state_d = ST_COMPRESS;
          end else if (item_i.op == OP_FINISH) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // zero fill to the length slot, or to the block end on overflow
        if (fill_q > LenPos) begin
          put      = 1'b1;
          put_byte = 8'h00;
          if (fill_q == 7'd127) begin
            start   = 1'b1;
            state_d = ST_COMPRESS;
          end
        end else if (fill_q < LenPos) begin
          put      = 1'b1;
          put_byte = 8'h00;
        end else begin
          start   = 1'b1;
          state_d = ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        if (rnd_q == 7'(Rounds)) begin
          if (fin_q && fill_q == LenPos) state_d = ST_EMIT;
          else if (fin_q)                state_d = ST_PAD;
          else                           state_d = ST_COLLECT;
        end
      end
      ST_EMIT: begin
        if (take && widx_q == 2'd3) state_d = ST_COLLECT;
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_COLLECT;
    else         state_q <= state_d;
  end

  // payload: block buffer and schedule window
  always_ff @(posedge clk_i) begin
    if (put) begin
      blk_q[fill_q[6:3]][8*(7-fill_q[2:0]) +: 8] <= put_byte;
    end
    if (len_load) begin
      blk_q[14] <= len_q[127:64];
      blk_q[15] <= len_q[63:0];
    end
    if (start) begin
      for (int i = 0; i < 16; i++) w_q[i] <= wload[i];
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == ST_COMPRESS && rnd_q != 7'(Rounds)) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= s1 + w_q[9] + s0 + w_q[0];
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
    if (state_q == ST_EMIT && take) begin
      oword_q <= (widx_q == 2'd3) ? (h_q[3] & TruncMask) : h_q[{1'b0, widx_q}];
      oidx_q  <= widx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i));
      fill_q   <= '0;
      len_q    <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      widx_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (state_q == ST_COLLECT && item_valid_i) begin
        if (item_i.op == OP_FINISH) fin_q <= 1'b1;
        else                        len_q <= len_q + 128'd8;
      end
      if (start) begin
        rnd_q  <= '0;
        fill_q <= len_load ? LenPos : 7'd0;
      end else if (put) begin
        fill_q <= fill_q + 7'd1;
      end else if (state_q == ST_COMPRESS) begin
        if (rnd_q == 7'(Rounds)) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (!(fin_q && fill_q == LenPos)) fill_q <= '0;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
      if (state_q == ST_EMIT && take) begin
        ovalid_q <= 1'b1;
        widx_q   <= widx_q + 2'd1;
        if (widx_q == 2'd3) begin
          for (int i = 0; i < 8; i++) h_q[i] <= iv(3'(i));
          fill_q <= '0;
          len_q  <= '0;
          fin_q  <= 1'b0;
        end
      end else if (take) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_if.valid       = ovalid_q;
  assign out_if.digest_word = oword_q;
  assign out_if.word_index  = oidx_q;
  assign out_if.last        = (oidx_q == 2'd3);
endmodule

// ===== src/sha512_224_hash_engine.sv =====
// Top level of the SHA-512/224 hash engine.
// Bytes enter through a four-entry queue and are packed into the block
// buffer at one per cycle while the core collects. The cycle that takes
// the 128th byte of a block starts the single-round compression unit,
// which keeps the core busy; the queue then fills and the input stalls. A
// finish writes the 0x80 byte and then one zero byte per cycle up to the
// length slot (at most 112 zero bytes in a block), loads the length as it
// starts the compression, compresses once, or twice when the padding
// spills into an extra block, then presents four digest words at up to one
// per cycle, the last with its low 32 bits zero, and starts a new message.
// No byte is taken while padding, compressing or presenting the digest.
module sha512_224_hash_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  sha512_224_in_if.sink    in_if,
  sha512_224_out_if.source out_if
);
  import sha512_224_pkg::*;

  item_t item;
  logic  item_valid, item_ready;

  sha512_224_front u_front (
    .clk_i, .rst_ni, .in_if,
    .item_o(item), .item_valid_o(item_valid), .item_ready_i(item_ready)
  );

  sha512_224_core u_core (
    .clk_i, .rst_ni,
    .item_i(item), .item_valid_i(item_valid), .item_ready_o(item_ready),
    .out_if
  );
endmodule

// ===== src/sha512_224_checker.sv =====
// Port-level checks for the hash engine, bound to the top level.
module sha512_224_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_word,
  input logic [1:0]  out_index,
  input logic        out_last
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_index == 2'd3)))
    else $error("last flag mismatch");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_last |-> out_word[31:0] == 32'd0)
    else $error("final word not truncated");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("stalled word changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last ##1 out_valid |->
      out_index == $past(out_index) + 2'd1)
    else $error("word index out of order");
endmodule

bind sha512_224_hash_engine sha512_224_checker u_checker (
  .clk_i, .rst_ni,
  .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_word(out_if.digest_word), .out_index(out_if.word_index),
  .out_last(out_if.last)
);
